@@ rtl/core/best_fit_chunk_allocator_macros.svh @@
// Assertion helpers for the allocator RTL.
`ifndef BEST_FIT_CHUNK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_CHUNK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFCA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define BFCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ rtl/core/bfca_pkg.sv @@
package bfca_pkg;

  localparam int NUM_CHUNKS = 1024;
  localparam int IDX_W      = $clog2(NUM_CHUNKS);
  localparam int LEN_W      = IDX_W + 1;

  localparam logic [16:0] CHUNK_BYTES_RST = 17'd64;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_NO_FIT   = 2'd1;
  localparam status_t STATUS_BAD_FREE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_AW0,
    ST_AW1,
    ST_FR0,
    ST_FR1,
    ST_FR2,
    ST_FR3,
    ST_FW0,
    ST_FW1,
    ST_FIN
  } state_t;

endpackage

@@ rtl/core/best_fit_chunk_allocator.sv @@
// Sequence: an allocate runs the serial divider, then a scan of the whole free-run
// table, then pick and commit before done is raised (no commit when nothing fits).
// A free reads both neighbours and merges, but ends after the lookup if no allocation starts there.
// Throughput: one word at a time; the next word may be accepted while done is high.
// Reset: a clearing pass initializes the three tables, busy is high.
// The result strobe lasts one cycle; the receiver cannot stall.
`include "best_fit_chunk_allocator_macros.svh"
module best_fit_chunk_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type,
  input  logic [31:0]                request_bytes,
  input  logic [9:0]                 free_chunk,
  input  logic                       cfg_we,
  input  logic [16:0]                cfg_wdata,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [9:0]                 start_chunk,
  output logic [25:0]                byte_offset,
  output logic [10:0]                chunks_taken,
  output logic [10:0]                free_chunks,
  output logic [9:0]                 free_fragments,
  output logic [10:0]                live_allocations
);
  import bfca_pkg::*;

  state_t state, state_next;

  logic [16:0] chunk_bytes;
  logic [16:0] cb_eff;

  // Tables.
  logic [LEN_W-1:0] frl_mem [NUM_CHUNKS];
  logic [IDX_W-1:0] frh_mem [NUM_CHUNKS];
  logic [LEN_W-1:0] alc_mem [NUM_CHUNKS];

  logic             frl_we, frh_we, alc_we;
  logic [IDX_W-1:0] frl_waddr, frh_waddr, alc_waddr;
  logic [IDX_W-1:0] frl_raddr, frh_raddr, alc_raddr;
  logic [LEN_W-1:0] frl_wdata, alc_wdata;
  logic [IDX_W-1:0] frh_wdata;
  logic [LEN_W-1:0] frl_rdata, alc_rdata;
  logic [IDX_W-1:0] frh_rdata;

  logic [IDX_W-1:0] clr_idx;
  logic [LEN_W-1:0] scan_idx;
  logic             scan_vld;
  logic [IDX_W-1:0] scan_ridx;

  logic             req_free;
  logic [IDX_W-1:0] req_chunk;

  logic             div_start, div_done, div_rem_nz;
  logic [31:0]      div_q;
  logic [32:0]      need_full;

  logic [LEN_W-1:0] need;
  logic             need_big;
  logic             found;
  logic [IDX_W-1:0] best;
  logic [LEN_W-1:0] best_len;
  logic             split;

  logic [LEN_W-1:0] flen;
  logic [IDX_W-1:0] prev_head;
  logic [LEN_W-1:0] end_idx;
  logic [IDX_W-1:0] run_start;
  logic [LEN_W-1:0] run_end;
  logic             prev_m, next_m;
  logic             prev_hit, next_hit;
  logic [LEN_W:0]   prev_sum;

  logic [LEN_W-1:0] free_total;
  logic [IDX_W-1:0] frag_cnt;
  logic [LEN_W-1:0] alloc_cnt;

  logic             res_ok;
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_start;
  logic [LEN_W-1:0] res_taken;
  logic [26:0]      product;

  logic             accept;

  assign accept    = start && !busy;
  assign cb_eff    = (chunk_bytes == '0) ? 17'd1 : chunk_bytes;
  assign div_start = accept && !req_type;
  assign need_full = {1'b0, div_q} + {32'd0, div_rem_nz};
  assign split     = best_len != need;
  assign product   = {17'd0, res_start} * {10'd0, cb_eff};

  assign prev_sum = {2'b00, prev_head} + {1'b0, frl_rdata};
  assign prev_hit = (req_chunk != '0) && (frl_rdata != '0) &&
                    (prev_sum == {2'b00, req_chunk});
  assign next_hit = (end_idx < LEN_W'(NUM_CHUNKS)) && (frl_rdata != '0);

  bfca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (request_bytes),
    .divisor  (cb_eff),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rem_nz)
  );

  always_ff @(posedge clk) begin
    if (frl_we) frl_mem[frl_waddr] <= frl_wdata;
    if (frh_we) frh_mem[frh_waddr] <= frh_wdata;
    if (alc_we) alc_mem[alc_waddr] <= alc_wdata;
    frl_rdata <= frl_mem[frl_raddr];
    frh_rdata <= frh_mem[frh_raddr];
    alc_rdata <= alc_mem[alc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      chunk_bytes <= CHUNK_BYTES_RST;
      clr_idx     <= '0;
      free_total  <= LEN_W'(NUM_CHUNKS);
      frag_cnt    <= IDX_W'(1);
      alloc_cnt   <= '0;
      done        <= 1'b0;
      scan_vld    <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= state == ST_FIN;
      scan_vld <= state == ST_SCAN;
      if (cfg_we) chunk_bytes <= cfg_wdata;
      if (state == ST_CLEAR) clr_idx <= clr_idx + IDX_W'(1);
      if (state == ST_FW1) begin
        free_total <= free_total + flen;
        alloc_cnt  <= alloc_cnt - LEN_W'(1);
        frag_cnt   <= frag_cnt + IDX_W'(1) - IDX_W'(prev_m) - IDX_W'(next_m);
      end
      if (state == ST_AW1) begin
        free_total <= free_total - need;
        alloc_cnt  <= alloc_cnt + LEN_W'(1);
        if (!split) frag_cnt <= frag_cnt - IDX_W'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    scan_ridx <= scan_idx[IDX_W-1:0];
    if (accept) begin
      req_free  <= req_type;
      req_chunk <= free_chunk;
      found     <= 1'b0;
      scan_idx  <= '0;
    end
    if (state == ST_DIV && div_done) begin
      need_big <= need_full > 33'(NUM_CHUNKS);
      need     <= (need_full == '0) ? LEN_W'(1) : need_full[LEN_W-1:0];
    end
    if (state == ST_SCAN) scan_idx <= scan_idx + LEN_W'(1);
    if (scan_vld && frl_rdata != '0 && !need_big && frl_rdata >= need &&
        (!found || frl_rdata < best_len)) begin
      found    <= 1'b1;
      best     <= scan_ridx;
      best_len <= frl_rdata;
    end
    case (state)
      ST_PICK: begin
        res_ok     <= found;
        res_status <= found ? STATUS_OK : STATUS_NO_FIT;
        res_start  <= found ? best : '0;
        res_taken  <= found ? need : '0;
      end
      ST_FR1: begin
        flen       <= alc_rdata;
        prev_head  <= frh_rdata;
        end_idx    <= {1'b0, req_chunk} + alc_rdata;
        res_ok     <= alc_rdata != '0;
        res_status <= (alc_rdata != '0) ? STATUS_OK : STATUS_BAD_FREE;
        res_start  <= (alc_rdata != '0) ? req_chunk : '0;
        res_taken  <= alc_rdata;
      end
      ST_FR2: begin
        prev_m    <= prev_hit;
        run_start <= prev_hit ? prev_head : req_chunk;
      end
      ST_FR3: begin
        next_m  <= next_hit;
        run_end <= next_hit ? end_idx + frl_rdata : end_idx;
      end
      ST_FIN: begin
        status           <= res_status;
        start_chunk      <= res_start;
        chunks_taken     <= res_taken;
        byte_offset      <= res_ok ? product[25:0] : '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    frl_we    = 1'b0;
    frh_we    = 1'b0;
    alc_we    = 1'b0;
    frl_waddr = '0;
    frh_waddr = '0;
    alc_waddr = '0;
    frl_wdata = '0;
    frh_wdata = '0;
    alc_wdata = '0;
    frl_raddr = scan_idx[IDX_W-1:0];
    frh_raddr = req_chunk - IDX_W'(1);
    alc_raddr = req_chunk;
    case (state)
      ST_CLEAR: begin
        frl_we    = 1'b1;
        frh_we    = 1'b1;
        alc_we    = 1'b1;
        frl_waddr = clr_idx;
        frh_waddr = clr_idx;
        alc_waddr = clr_idx;
        frl_wdata = (clr_idx == '0) ? LEN_W'(NUM_CHUNKS) : '0;
        if (clr_idx == IDX_W'(NUM_CHUNKS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = req_type ? ST_FR0 : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx == LEN_W'(NUM_CHUNKS - 1)) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: state_next = ST_PICK;
      ST_PICK: state_next = found ? ST_AW0 : ST_FIN;
      ST_AW0: begin
        frl_we    = 1'b1;
        frl_waddr = best;
        alc_we    = 1'b1;
        alc_waddr = best;
        alc_wdata = need;
        frh_we    = split;
        frh_waddr = best + best_len[IDX_W-1:0] - IDX_W'(1);
        frh_wdata = best + need[IDX_W-1:0];
        state_next = ST_AW1;
      end
      ST_AW1: begin
        frl_we    = split;
        frl_waddr = best + need[IDX_W-1:0];
        frl_wdata = best_len - need;
        state_next = ST_FIN;
      end
      ST_FR0: state_next = ST_FR1;
      ST_FR1: begin
        frl_raddr  = frh_rdata;
        state_next = (alc_rdata == '0) ? ST_FIN : ST_FR2;
      end
      ST_FR2: begin
        frl_raddr  = end_idx[IDX_W-1:0];
        state_next = ST_FR3;
      end
      ST_FR3: state_next = ST_FW0;
      ST_FW0: begin
        frl_we    = next_m;
        frl_waddr = end_idx[IDX_W-1:0];
        alc_we    = 1'b1;
        alc_waddr = req_chunk;
        frh_we    = 1'b1;
        frh_waddr = run_end[IDX_W-1:0] - IDX_W'(1);
        frh_wdata = run_start;
        state_next = ST_FW1;
      end
      ST_FW1: begin
        frl_we    = 1'b1;
        frl_waddr = run_start;
        frl_wdata = run_end - {1'b0, run_start};
        state_next = ST_FIN;
      end
      ST_FIN: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy             = state != ST_IDLE;
  assign free_chunks      = free_total;
  assign free_fragments   = frag_cnt;
  assign live_allocations = alloc_cnt;

  `BFCA_ASSERT_NEXT(a_fin_strobes, state == ST_FIN, done)
  `BFCA_ASSERT_NEXT(a_accept_busy, accept, busy)
  `BFCA_ASSERT_NOW(a_free_bound, done, free_total <= LEN_W'(NUM_CHUNKS))
  `BFCA_ASSERT_NOW(a_nofit_nochange, done && status == STATUS_NO_FIT, chunks_taken == '0)

endmodule

@@ rtl/core/bfca_div.sv @@
module bfca_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic        rem_nz
);
  logic        running;
  logic [4:0]  cnt;
  logic [31:0] q;
  logic [16:0] rem;
  logic [16:0] dvs;
  logic [17:0] trial;
  logic [17:0] diff;
  logic        ge;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, q[31]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      rem <= ge ? diff[16:0] : trial[16:0];
      q   <= {q[30:0], ge};
    end
  end

  assign quotient = q;
  assign rem_nz   = rem != '0;

endmodule

@@ tb/tb_best_fit_chunk_allocator.sv @@
module tb_best_fit_chunk_allocator;
  import bfca_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = 1'b0;
  logic [31:0] request_bytes = '0;
  logic [9:0]  free_chunk = '0;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        done;
  logic [1:0]  status;
  logic [9:0]  start_chunk;
  logic [25:0] byte_offset;
  logic [10:0] chunks_taken;
  logic [10:0] free_chunks;
  logic [9:0]  free_fragments;
  logic [10:0] live_allocations;

  best_fit_chunk_allocator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .request_bytes(request_bytes), .free_chunk(free_chunk),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .status(status),
    .start_chunk(start_chunk), .byte_offset(byte_offset),
    .chunks_taken(chunks_taken), .free_chunks(free_chunks),
    .free_fragments(free_fragments), .live_allocations(live_allocations)
  );

  always #5 clk = ~clk;

  typedef struct {
    status_t     st;
    logic [9:0]  chunk;
    logic [25:0] offset;
    logic [10:0] taken;
    logic [10:0] nfree;
    logic [9:0]  nfrag;
    logic [10:0] nlive;
  } grant_t;

  grant_t grants_due[$];

  // Shadow copy of the allocator tables.
  int unsigned run_len [NUM_CHUNKS];
  int unsigned run_head[NUM_CHUNKS];
  int unsigned owned   [NUM_CHUNKS];
  int unsigned pool_free, pool_frags, pool_live;
  logic [16:0] chunk_size;

  int errors = 0;
  int cycles = 0;
  bit no_gaps = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (!rst && done) begin
      if (grants_due.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        g = grants_due.pop_front();
        if (status !== g.st) report("status", status, g.st);
        if (start_chunk !== g.chunk) report("start_chunk", start_chunk, g.chunk);
        if (byte_offset !== g.offset) report("byte_offset", byte_offset, g.offset);
        if (chunks_taken !== g.taken) report("chunks_taken", chunks_taken, g.taken);
        if (free_chunks !== g.nfree) report("free_chunks", free_chunks, g.nfree);
        if (free_fragments !== g.nfrag) report("free_fragments", free_fragments, g.nfrag);
        if (live_allocations !== g.nlive)
          report("live_allocations", live_allocations, g.nlive);
      end
    end
  end

  function automatic longint unsigned eff_size();
    return (chunk_size == 0) ? 1 : chunk_size;
  endfunction

  task automatic model_reset();
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      run_len[i] = 0;
      run_head[i] = 0;
      owned[i] = 0;
    end
    run_len[0] = NUM_CHUNKS;
    pool_free = NUM_CHUNKS;
    pool_frags = 1;
    pool_live = 0;
    chunk_size = CHUNK_BYTES_RST;
  endtask

  task automatic set_run(input int unsigned s, input int unsigned n);
    run_len[s] = n;
    run_head[s + n - 1] = s;
  endtask

  task automatic predict_grant(input logic rt, input logic [31:0] nbytes,
                               input logic [9:0] fc, output grant_t g);
    longint unsigned need, cb;
    int unsigned best, best_n, len, s, e, p;
    bit found;
    cb = eff_size();
    g.st = STATUS_OK;
    g.chunk = '0;
    g.offset = '0;
    g.taken = '0;
    found = 0;
    best = 0;
    best_n = 0;
    if (!rt) begin
      need = (longint'(nbytes) + cb - 1) / cb;
      if (need == 0) need = 1;
      for (int i = 0; i < NUM_CHUNKS; i++)
        if (run_len[i] != 0 && run_len[i] >= need && (!found || run_len[i] < best_n)) begin
          found = 1;
          best = i;
          best_n = run_len[i];
        end
      if (!found) begin
        g.st = STATUS_NO_FIT;
      end else begin
        run_len[best] = 0;
        if (best_n != need) set_run(32'(best + need), 32'(best_n - need));
        else pool_frags--;
        owned[best] = 32'(need);
        pool_live++;
        pool_free -= 32'(need);
        g.chunk = 10'(best);
        g.taken = 11'(need);
        g.offset = 26'(longint'(best) * cb);
      end
    end else if (owned[fc] == 0) begin
      g.st = STATUS_BAD_FREE;
    end else begin
      len = owned[fc];
      s = fc;
      e = fc + len;
      owned[fc] = 0;
      pool_live--;
      pool_free += len;
      pool_frags++;
      if (fc > 0) begin
        p = run_head[fc - 1];
        if (run_len[p] != 0 && p + run_len[p] == fc) begin
          run_len[p] = 0;
          s = p;
          pool_frags--;
        end
      end
      if (e < NUM_CHUNKS && run_len[e] != 0) begin
        p = e + run_len[e];
        run_len[e] = 0;
        e = p;
        pool_frags--;
      end
      set_run(s, e - s);
      g.chunk = fc;
      g.taken = 11'(len);
      g.offset = 26'(longint'(fc) * cb);
    end
    g.nfree = 11'(pool_free);
    g.nfrag = 10'(pool_frags);
    g.nlive = 11'(pool_live);
  endtask

  // Sends one word; start is left high so a back-to-back word needs no drop and re-raise of start.
  task automatic send_word(input logic rt, input logic [31:0] nbytes, input logic [9:0] fc);
    int gap;
    grant_t g;
    gap = no_gaps ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(0, 3) : $urandom_range(20, 200));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rt;
    request_bytes <= nbytes;
    free_chunk <= fc;
    do @(posedge clk); while (busy);
    predict_grant(rt, nbytes, fc, g);
    grants_due.push_back(g);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_chunk_size(input logic [16:0] v);
    drain();
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    chunk_size = v;
  endtask

  function automatic logic [31:0] bytes_for(input int unsigned k);
    longint unsigned cb;
    cb = eff_size();
    return 32'((longint'(k) - 1) * cb + $urandom_range(1, int'(cb)));
  endfunction

  function automatic int pick_live();
    int starts[$];
    for (int i = 0; i < NUM_CHUNKS; i++) if (owned[i] != 0) starts.push_back(i);
    if (starts.size() == 0) return -1;
    return starts[$urandom_range(0, starts.size() - 1)];
  endfunction

  task automatic test_alloc_and_coalesce();
    send_word(1'b0, 32'd0, '0);
    send_word(1'b0, 32'd1, '0);
    send_word(1'b0, 32'd64, '0);
    send_word(1'b0, 32'd65, '0);
    send_word(1'b0, 32'd200, '0);
    send_word(1'b1, '0, 10'd1);
    send_word(1'b1, '0, 10'd3);
    send_word(1'b1, '0, 10'd2);
    send_word(1'b1, '0, 10'd0);
    send_word(1'b0, 32'd64, '0);
    send_word(1'b1, '0, 10'd5);
    send_word(1'b1, '0, 10'd0);
    send_word(1'b0, 32'd65536, '0);
    send_word(1'b1, '0, 10'd0);
  endtask

  task automatic test_errors();
    send_word(1'b1, 32'hFFFF_FFFF, 10'd1023);
    send_word(1'b1, '0, 10'd0);
    send_word(1'b0, 32'hFFFF_FFFF, 10'h3FF);
    send_word(1'b0, 32'd65537, '0);
    send_word(1'b0, 32'd65536, '0);
    send_word(1'b0, 32'd1, '0);
    send_word(1'b1, '0, 10'd0);
    send_word(1'b1, '0, 10'd0);
  endtask

  task automatic test_size_extremes();
    write_chunk_size(17'd0);
    send_word(1'b0, 32'd0, '0);
    send_word(1'b0, 32'd3, '0);
    write_chunk_size(17'h1FFFF);
    send_word(1'b0, 32'h0001_FFFF, '0);
    send_word(1'b0, 32'h0001_FFFF * 1000, '0);
    send_word(1'b1, '0, 10'd1);
  endtask

  task automatic test_random(input int count, input logic [16:0] size);
    int live, r;
    write_chunk_size(size);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      live = pick_live();
      if (r < 50 || live < 0)
        send_word(1'b0, bytes_for($urandom_range(0, 7) == 0 ? $urandom_range(1, 1024)
                                                          : $urandom_range(1, 16)),
                  10'($urandom));
      else if (r < 88)
        send_word(1'b1, $urandom, 10'(live));
      else if (r < 94)
        send_word(1'b1, $urandom, 10'($urandom));
      else
        send_word(1'b0, $urandom, 10'($urandom));
    end
    no_gaps = 0;
  endtask

  initial begin
    model_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_chunk_size(17'd64);
    test_alloc_and_coalesce();
    test_errors();
    test_size_extremes();
    test_random(80, 17'd64);
    test_random(80, 17'd1);
    test_random(70, 17'd0);
    test_random(80, 17'h10000);
    test_random(70, 17'h1FFFF);
    test_random(80, 17'd3);
    test_random(80, 17'd64);
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
